[sv/imu_frs_pkg.sv]
// ----------------------------------------------------------------------------
// imu_frs_pkg
// shared types, constants and scaling functions of the imu frame parser
// ----------------------------------------------------------------------------
package imu_frs_pkg;

    localparam int unsigned FRAME_LEN  = 11;
    localparam int unsigned WIN_DEPTH  = FRAME_LEN - 1;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned ANGLE_W    = 24;
    localparam int unsigned RATE_W     = 27;
    localparam int unsigned TDATA_W    = 160;

    localparam logic [7:0] HDR_BYTE    = 8'h55;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);

    // decoded frame from the window stage
    typedef struct packed {
        logic        ok;
        logic [7:0]  kind;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
    } frame_t;

    // one result item
    typedef struct packed {
        logic signed [RATE_W-1:0]  rate_z_fix;
        logic signed [RATE_W-1:0]  rate_y_fix;
        logic signed [RATE_W-1:0]  rate_x_fix;
        logic signed [ANGLE_W-1:0] yaw_fix;
        logic signed [ANGLE_W-1:0] pitch_fix;
        logic signed [ANGLE_W-1:0] roll_fix;
    } result_t;

    function automatic logic signed [ANGLE_W-1:0] scale_angle(input logic [15:0] raw);
        logic signed [ANGLE_W:0] prod;
        prod = (ANGLE_W+1)'($signed(raw)) * (ANGLE_W+1)'(180);
        return prod[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [RATE_W-1:0] scale_rate(input logic [15:0] raw);
        logic signed [RATE_W:0] prod;
        prod = (RATE_W+1)'($signed(raw)) * (RATE_W+1)'(2000);
        return prod[RATE_W-1:0];
    endfunction

endpackage

[sv/imu_frame_parser_resync_unit.sv]
// ----------------------------------------------------------------------------
// imu_frame_parser_resync_unit
// eleven byte imu serial frame parser with header and checksum resync
// ----------------------------------------------------------------------------
// One received byte is taken per item and the unit sustains one item every
// clock cycle. A byte is held in an input register, then the window check,
// decode and scaling are done combinationally and an angle result is held in
// an output register. The unit stalls only while the output register holds a
// result that the downstream side has not taken.
module imu_frame_parser_resync_unit
    import imu_frs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // roll_fix, pitch_fix, yaw_fix, rate_x_fix, rate_y_fix, rate_z_fix, zero pad
    output logic [TDATA_W-1:0] m_tdata
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_data_reg;
    logic       fire;
    frame_t     frame;
    logic       res_valid;
    result_t    res;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    imu_frs_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    imu_frs_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .frame     (frame),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

endmodule

[sv/imu_frs_framer.sv]
// ----------------------------------------------------------------------------
// imu_frs_framer
// byte window with header and additive checksum test, drops the oldest byte
// on a failed check
// ----------------------------------------------------------------------------
module imu_frs_framer
    import imu_frs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    logic [7:0]       window_reg [WIN_DEPTH];
    logic [7:0]       window_next [WIN_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       frm [FRAME_LEN];
    logic [7:0]       sum;
    logic             full;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            frm[i] = window_reg[i];
        end
        frm[FRAME_LEN-1] = rx_byte;

        sum = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            sum = sum + frm[i];
        end

        full       = (count_reg == CNT_FULL);
        frame.ok   = full && (frm[0] == HDR_BYTE) && (sum == frm[FRAME_LEN-1]);
        frame.kind = frm[1];
        frame.v0   = {frm[3], frm[2]};
        frame.v1   = {frm[5], frm[4]};
        frame.v2   = {frm[7], frm[6]};
    end

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (fire)
        begin
            if (!full)
            begin
                window_next[count_reg] = rx_byte;
                count_next             = count_reg + CNT_W'(1);
            end
            else if (frame.ok)
            begin
                count_next = '0;
            end
            else
            begin
                // slide by one, keep ten bytes
                for (int i = 0; i < WIN_DEPTH; i++)
                begin
                    window_next[i] = frm[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

[sv/imu_frs_decode.sv]
// ----------------------------------------------------------------------------
// imu_frs_decode
// rate cache and fixed point scaling of good frames
// ----------------------------------------------------------------------------
module imu_frs_decode
    import imu_frs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  frame_t  frame,
    output logic    res_valid,
    output result_t res
);

    logic [15:0] rate_reg [3];
    logic        is_rate;

    assign is_rate   = frame.ok && (frame.kind == TYPE_RATE);
    assign res_valid = frame.ok && (frame.kind == TYPE_ANGLE);

    always_comb
    begin
        res.roll_fix   = scale_angle(frame.v0);
        res.pitch_fix  = scale_angle(frame.v1);
        res.yaw_fix    = scale_angle(frame.v2);
        res.rate_x_fix = scale_rate(rate_reg[0]);
        res.rate_y_fix = scale_rate(rate_reg[1]);
        res.rate_z_fix = scale_rate(rate_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg[0] <= '0;
            rate_reg[1] <= '0;
            rate_reg[2] <= '0;
        end
        else if (fire && is_rate)
        begin
            rate_reg[0] <= frame.v0;
            rate_reg[1] <= frame.v1;
            rate_reg[2] <= frame.v2;
        end
    end

endmodule
